// ===== hdl/spo_pkg.sv =====
// ----------------------------------------------------------------------------
// spo_pkg
// shared constants for the sphere pair overlap scan: field widths, stream
// layouts and parameter defaults
// ----------------------------------------------------------------------------
package spo_pkg;

	localparam int DEF_MAX_BODIES  = 64;
	localparam int DEF_COORD_BITS  = 24;

	localparam int IN_COORD_W      = 24;
	localparam int RADIUS_W        = 23;
	localparam int IDX_OUT_W       = 6;

	localparam int S_TDATA_W       = 96;
	localparam int S_TUSER_W       = 1;
	localparam int M_TDATA_W       = 16;

	localparam int POS_X_LSB       = 0;
	localparam int POS_Y_LSB       = IN_COORD_W;
	localparam int POS_Z_LSB       = 2 * IN_COORD_W;
	localparam int RADIUS_LSB      = 3 * IN_COORD_W;

endpackage

// ===== hdl/spo_front.sv =====
// ----------------------------------------------------------------------------
// spo_front
// accepts spheres, tracks the set size, drops spheres once the store is full
// and pushes a scan job (index and sphere) into the job queue
// ----------------------------------------------------------------------------
module spo_front #(
	parameter int MAX_BODIES  = spo_pkg::DEF_MAX_BODIES,
	parameter int COORD_BITS  = spo_pkg::DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [spo_pkg::S_TDATA_W-1:0]         s_tdata,
	input  logic [spo_pkg::S_TUSER_W-1:0]         s_tuser,
	input  logic                                  q_full,
	output logic                                  q_push,
	output logic [$clog2(MAX_BODIES)+3*COORD_BITS+spo_pkg::RADIUS_W-1:0] q_data
);

	localparam int IDX_W = $clog2(MAX_BODIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int CW    = COORD_BITS;
	localparam int RW    = spo_pkg::RADIUS_W;
	localparam int IW    = spo_pkg::IN_COORD_W;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cnt_sel;
	logic             accept;
	logic             room;
	logic [IW-1:0]    raw_x, raw_y, raw_z;
	logic [CW-1:0]    x, y, z;
	logic [RW-1:0]    r;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign cnt_sel  = s_tuser[0] ? '0 : count_q;
	assign room     = cnt_sel < CNT_W'(MAX_BODIES);
	assign q_push   = accept && room;

	assign raw_x = s_tdata[spo_pkg::POS_X_LSB +: IW];
	assign raw_y = s_tdata[spo_pkg::POS_Y_LSB +: IW];
	assign raw_z = s_tdata[spo_pkg::POS_Z_LSB +: IW];
	assign r     = s_tdata[spo_pkg::RADIUS_LSB +: RW];
	assign x     = CW'(raw_x);
	assign y     = CW'(raw_y);
	assign z     = CW'(raw_z);

	assign q_data = {cnt_sel[IDX_W-1:0], x, y, z, r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= room ? cnt_sel + CNT_W'(1) : cnt_sel;
		end
	end

endmodule

// ===== hdl/spo_queue.sv =====
// ----------------------------------------------------------------------------
// spo_queue
// two-entry job queue between the front and the scan engine
// ----------------------------------------------------------------------------
module spo_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	output logic         valid,
	output logic [W-1:0] dout,
	input  logic         pop
);

	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

endmodule

// ===== hdl/spo_back.sv =====
// ----------------------------------------------------------------------------
// spo_back
// scan engine: stores each job's sphere, walks the earlier spheres through a
// compare pipeline and emits overlapping pairs, one held back to place tlast
// ----------------------------------------------------------------------------
module spo_back #(
	parameter int MAX_BODIES  = spo_pkg::DEF_MAX_BODIES,
	parameter int COORD_BITS  = spo_pkg::DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	input  logic [$clog2(MAX_BODIES)+3*COORD_BITS+spo_pkg::RADIUS_W-1:0] q_data,
	output logic                                  q_pop,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [spo_pkg::M_TDATA_W-1:0]         m_tdata,
	output logic                                  m_tlast
);

	localparam int IDX_W = $clog2(MAX_BODIES);
	localparam int CW    = COORD_BITS;
	localparam int RW    = spo_pkg::RADIUS_W;
	localparam int RS_W  = RW + 1;
	localparam int DW    = (CW + 1 > RS_W) ? CW + 1 : RS_W;
	localparam int SQ_W  = 2 * RS_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int ENT_W = 3 * CW + RW;
	localparam int OW    = spo_pkg::IDX_OUT_W;
	localparam int PAD_W = spo_pkg::M_TDATA_W - 2 * OW;

	function automatic logic [DW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic signed [CW:0] d;
		d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
		if (d < 0) begin
			d = -d;
		end
		return DW'(unsigned'(d));
	endfunction

	logic [ENT_W-1:0] mem [MAX_BODIES];

	// job and issue control
	logic             active_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] n_q;
	logic [ENT_W-1:0] ent_q;
	logic             adv;
	logic             issue;
	logic             at_end;

	// stage 1: stored and current sphere
	logic             v_s1, end_s1;
	logic [IDX_W-1:0] idx_s1, n_s1;
	logic [ENT_W-1:0] st_s1, cur_s1;

	// stage 2: axis distances
	logic             v_s2, end_s2, far_s2;
	logic [IDX_W-1:0] idx_s2, n_s2;
	logic [RS_W-1:0]  dx_s2, dy_s2, dz_s2, rs_s2;

	// stage 3: squares
	logic             v_s3, end_s3, far_s3;
	logic [IDX_W-1:0] idx_s3, n_s3;
	logic [SQ_W-1:0]  sqx_s3, sqy_s3, sqz_s3, rs2_s3;

	// held pair and output register
	logic             pend_v_q;
	logic [IDX_W-1:0] pend_a_q, pend_b_q;
	logic             m_tvalid_q;
	logic [IDX_W-1:0] out_a_q, out_b_q;
	logic             out_last_q;

	logic [DW-1:0]    dx, dy, dz;
	logic [RS_W-1:0]  rs;
	logic             far;
	logic [SUM_W-1:0] dist2;
	logic             hit;
	logic             need;

	assign q_pop  = q_valid && !active_q;
	assign at_end = i_q == n_q;
	assign issue  = adv && active_q;

	assign dx  = abs_diff(st_s1[3*CW+RW-1 -: CW], cur_s1[3*CW+RW-1 -: CW]);
	assign dy  = abs_diff(st_s1[2*CW+RW-1 -: CW], cur_s1[2*CW+RW-1 -: CW]);
	assign dz  = abs_diff(st_s1[CW+RW-1 -: CW], cur_s1[CW+RW-1 -: CW]);
	assign rs  = RS_W'(st_s1[RW-1:0]) + RS_W'(cur_s1[RW-1:0]);
	assign far = (dx >= DW'(rs)) || (dy >= DW'(rs)) || (dz >= DW'(rs));

	assign dist2 = SUM_W'(sqx_s3) + SUM_W'(sqy_s3) + SUM_W'(sqz_s3);
	assign hit   = v_s3 && !end_s3 && !far_s3 && (dist2 < SUM_W'(rs2_s3));
	assign need  = v_s3 && pend_v_q && (hit || end_s3);
	assign adv   = !need || !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {PAD_W'(0), OW'(out_b_q), OW'(out_a_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			i_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				i_q      <= '0;
			end else if (issue) begin
				if (at_end) begin
					active_q <= 1'b0;
				end else begin
					i_q <= i_q + IDX_W'(1);
				end
			end
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				if (v_s3 && end_s3) begin
					pend_v_q <= 1'b0;
				end else if (hit) begin
					pend_v_q <= 1'b1;
				end
			end
			if (adv && need) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mem[q_data[IDX_W+ENT_W-1 -: IDX_W]] <= q_data[ENT_W-1:0];
			n_q   <= q_data[IDX_W+ENT_W-1 -: IDX_W];
			ent_q <= q_data[ENT_W-1:0];
		end
		if (adv) begin
			st_s1  <= mem[i_q];
			cur_s1 <= ent_q;
			end_s1 <= at_end;
			idx_s1 <= i_q;
			n_s1   <= n_q;

			dx_s2  <= RS_W'(dx);
			dy_s2  <= RS_W'(dy);
			dz_s2  <= RS_W'(dz);
			rs_s2  <= rs;
			far_s2 <= far;
			end_s2 <= end_s1;
			idx_s2 <= idx_s1;
			n_s2   <= n_s1;

			sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
			sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
			sqz_s3 <= SQ_W'(dz_s2) * SQ_W'(dz_s2);
			rs2_s3 <= SQ_W'(rs_s2) * SQ_W'(rs_s2);
			far_s3 <= far_s2;
			end_s3 <= end_s2;
			idx_s3 <= idx_s2;
			n_s3   <= n_s2;

			if (hit) begin
				pend_a_q <= idx_s3;
				pend_b_q <= n_s3;
			end
		end
		if (adv && need) begin
			out_a_q    <= pend_a_q;
			out_b_q    <= pend_b_q;
			out_last_q <= end_s3;
		end
	end

endmodule

// ===== hdl/sphere_pair_overlap_scan.sv =====
// ----------------------------------------------------------------------------
// sphere_pair_overlap_scan
// all-pairs sphere overlap broad phase: each new sphere is tested against
// every earlier sphere of its set and overlapping index pairs are streamed out
//
//   port group   dir   fields, lowest bit up
//   s_*          in    tdata: pos_x, pos_y, pos_z, radius; tuser: new_set
//   m_*          out   tdata: index_a, index_b; tlast: last
//
// a sphere that finds n stored spheres holds the scan engine for a job pop,
// n compares and an end marker, one read of the sphere store each;
// its last pair passes the queue, the compare pipeline and the held pair
// register before it reaches the output register
// up to two jobs wait in the queue, so input is taken while a scan runs
// output stalls freeze the pipeline if a pair is due; reset clears set size
// ----------------------------------------------------------------------------
module sphere_pair_overlap_scan #(
	parameter int MAX_BODIES  = spo_pkg::DEF_MAX_BODIES,
	parameter int COORD_BITS  = spo_pkg::DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [spo_pkg::S_TDATA_W-1:0] s_tdata,  // pos_x, pos_y, pos_z, radius
	input  logic [spo_pkg::S_TUSER_W-1:0] s_tuser,  // new_set
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [spo_pkg::M_TDATA_W-1:0] m_tdata,  // index_a, index_b
	output logic                          m_tlast
);

	localparam int JOB_W = $clog2(MAX_BODIES) + 3 * COORD_BITS + spo_pkg::RADIUS_W;

	logic             push;
	logic             full;
	logic [JOB_W-1:0] push_data;
	logic             job_valid;
	logic [JOB_W-1:0] job_data;
	logic             pop;

	spo_front #(
		.MAX_BODIES (MAX_BODIES),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (full),
		.q_push   (push),
		.q_data   (push_data)
	);

	spo_queue #(
		.W (JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.full   (full),
		.valid  (job_valid),
		.dout   (job_data),
		.pop    (pop)
	);

	spo_back #(
		.MAX_BODIES (MAX_BODIES),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (job_valid),
		.q_data   (job_data),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
